>>> rtl/core/btz_pkg.sv
`timescale 1ns / 1ps

package btz_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int COUNT_W    = 5;
	localparam int CUR_MA_W   = 14;
	localparam int VREG_MV_W  = 13;
	localparam int CUR_UA_W   = 24;
	localparam int VREG_UV_W  = 23;
	localparam int TEMP_W     = 12;

	localparam logic [9:0] UNIT_SCALE = 10'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WARM_ENTRIES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_ENTRIES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CUR_MA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCED_CUR_MA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_VREG_MV = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCED_VREG_MV = 3'd5;

	// opcodes; the remaining codes are rejected notifications
	localparam logic [2:0] OP_WARM      = 3'd0;
	localparam logic [2:0] OP_COOL      = 3'd1;
	localparam logic [2:0] OP_LOAD_WARM = 3'd2;
	localparam logic [2:0] OP_LOAD_COOL = 3'd3;
	localparam logic [2:0] OP_START     = 3'd4;

	localparam logic [3:0] ACT_ENABLE   = 4'd0;
	localparam logic [3:0] ACT_DECREASE = 4'd1;
	localparam logic [3:0] ACT_STOP     = 4'd2;
	localparam logic [3:0] ACT_SHUTDOWN = 4'd3;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_EVENT  = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] EN_NONE = 2'd0;
	localparam logic [1:0] EN_ON   = 2'd1;
	localparam logic [1:0] EN_OFF  = 2'd2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] thr;
		logic signed [TEMP_W-1:0] nlo;
		logic signed [TEMP_W-1:0] nhi;
		logic [3:0]               action;
		logic [3:0]               health;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic init;    // take a searching item (event or start)
		logic simple;  // take a load or rejected item, result next cycle
		logic fetch;   // read both tables at the search pointer, step down
		logic finish;  // read data hit: re-arm and post the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_search;
		logic hit;
	} dp_status_t;

endpackage

>>> rtl/core/btz_ctrl.sv
`timescale 1ns / 1ps

module btz_ctrl
	import btz_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t st,
	output dp_cmd_t    cmd,
	output logic       busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_CHECK
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.init   = start && st.needs_search;
				cmd.simple = start && !st.needs_search;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
			end
			S_CHECK: begin
				// keep one read in flight per cycle until the data hits
				cmd.finish = st.hit;
				cmd.fetch  = !st.hit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && st.needs_search) state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (st.hit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init, cmd.simple, cmd.fetch, cmd.finish}))
		else $error("more than one datapath command at once");

	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !busy)
		else $error("still busy after a finishing beat");

endmodule

>>> rtl/core/btz_dpath.sv
`timescale 1ns / 1ps

module btz_dpath
	import btz_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 st,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [2:0]                 opcode,
	input  logic [3:0]                 entry_index,
	input  logic signed [TEMP_W-1:0]   entry_threshold,
	input  logic signed [TEMP_W-1:0]   entry_next_low,
	input  logic signed [TEMP_W-1:0]   entry_next_high,
	input  logic [3:0]                 entry_action,
	input  logic [3:0]                 entry_health,
	output logic                       done,
	output logic [1:0]                 result_kind,
	output logic signed [TEMP_W-1:0]   armed_low,
	output logic signed [TEMP_W-1:0]   armed_high,
	output logic [3:0]                 matched_slot,
	output logic [3:0]                 action_taken,
	output logic [3:0]                 health_report,
	output logic [1:0]                 enable_write,
	output logic                       limits_write,
	output logic [CUR_UA_W-1:0]        current_limit_ua,
	output logic [VREG_UV_W-1:0]       voltage_limit_uv,
	output logic                       shutdown_notice
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// configuration
	logic [COUNT_W-1:0]   warm_n_q, cool_n_q;
	logic [CUR_MA_W-1:0]  cur_norm_q, cur_red_q;
	logic [VREG_MV_W-1:0] vreg_norm_q, vreg_red_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_n_q    <= COUNT_W'(1);
			cool_n_q    <= COUNT_W'(1);
			cur_norm_q  <= '0;
			cur_red_q   <= '0;
			vreg_norm_q <= '0;
			vreg_red_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WARM_ENTRIES:    warm_n_q    <= cfg_data[COUNT_W-1:0];
				REG_COOL_ENTRIES:    cool_n_q    <= cfg_data[COUNT_W-1:0];
				REG_NORMAL_CUR_MA:   cur_norm_q  <= cfg_data[CUR_MA_W-1:0];
				REG_REDUCED_CUR_MA:  cur_red_q   <= cfg_data[CUR_MA_W-1:0];
				REG_NORMAL_VREG_MV:  vreg_norm_q <= cfg_data[VREG_MV_W-1:0];
				REG_REDUCED_VREG_MV: vreg_red_q  <= cfg_data[VREG_MV_W-1:0];
				default: ;
			endcase
		end
	end

	// limits scale straight off the config registers
	logic [CUR_UA_W-1:0]  cur_norm_ua, cur_red_ua;
	logic [VREG_UV_W-1:0] vreg_norm_uv, vreg_red_uv;

	assign cur_norm_ua  = CUR_UA_W'(cur_norm_q) * CUR_UA_W'(UNIT_SCALE);
	assign cur_red_ua   = CUR_UA_W'(cur_red_q) * CUR_UA_W'(UNIT_SCALE);
	assign vreg_norm_uv = VREG_UV_W'(vreg_norm_q) * VREG_UV_W'(UNIT_SCALE);
	assign vreg_red_uv  = VREG_UV_W'(vreg_red_q) * VREG_UV_W'(UNIT_SCALE);

	// last valid slot, count clamped to 1..TABLE_DEPTH
	function automatic logic [IW-1:0] last_slot(input logic [COUNT_W-1:0] n);
		logic [IW-1:0] r;
		if (n == '0) begin
			r = '0;
		end else if (32'(n) > TABLE_DEPTH) begin
			r = IW'(TABLE_DEPTH - 1);
		end else begin
			r = IW'(32'(n) - 32'd1);
		end
		return r;
	endfunction

	// tables
	entry_t warm_mem [TABLE_DEPTH];
	entry_t cool_mem [TABLE_DEPTH];
	entry_t wr_entry;
	logic   wr_in_range;

	assign wr_entry    = '{thr: entry_threshold, nlo: entry_next_low, nhi: entry_next_high,
		action: entry_action, health: entry_health};
	assign wr_in_range = (32'(entry_index) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.simple && wr_in_range && opcode == OP_LOAD_WARM) begin
			warm_mem[IW'(entry_index)] <= wr_entry;
		end
		if (cmd.simple && wr_in_range && opcode == OP_LOAD_COOL) begin
			cool_mem[IW'(entry_index)] <= wr_entry;
		end
	end

	// search pointer and read port
	logic [2:0]    op_q;
	logic [IW-1:0] ptr_q, ptr_s1;
	entry_t        warm_rd_s1, cool_rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			op_q <= opcode;
			if (opcode == OP_WARM) begin
				ptr_q <= last_slot(warm_n_q);
			end else if (opcode == OP_COOL) begin
				ptr_q <= last_slot(cool_n_q);
			end else begin
				ptr_q <= '0;
			end
		end else if (cmd.fetch) begin
			if (ptr_q != '0) ptr_q <= ptr_q - 1'b1;
		end
		if (cmd.fetch) begin
			ptr_s1     <= ptr_q;
			warm_rd_s1 <= warm_mem[ptr_q];
			cool_rd_s1 <= cool_mem[ptr_q];
		end
	end

	logic signed [TEMP_W-1:0] low_q, high_q, key;
	entry_t                   rd;

	assign rd  = (op_q == OP_COOL) ? cool_rd_s1 : warm_rd_s1;
	assign key = (op_q == OP_COOL) ? low_q : high_q;

	assign st.needs_search = (opcode == OP_WARM) || (opcode == OP_COOL) || (opcode == OP_START);
	// slot 0 is the fallback, and a start always reads slot 0
	assign st.hit          = (ptr_s1 == '0) || (rd.thr == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (cmd.finish) begin
			low_q  <= rd.nlo;
			high_q <= rd.nhi;
		end
	end

	// result decode for a finishing beat
	logic [1:0]           en_d;
	logic                 lim_d, shut_d;
	logic [CUR_UA_W-1:0]  cur_d;
	logic [VREG_UV_W-1:0] volt_d;
	logic [31:0]          slot_wide;

	assign slot_wide = 32'(ptr_s1);

	always_comb begin
		en_d   = EN_NONE;
		lim_d  = 1'b0;
		shut_d = 1'b0;
		cur_d  = '0;
		volt_d = '0;
		unique case (rd.action)
			ACT_ENABLE: begin
				en_d   = EN_ON;
				lim_d  = 1'b1;
				cur_d  = cur_norm_ua;
				volt_d = vreg_norm_uv;
			end
			ACT_DECREASE: begin
				en_d   = EN_ON;
				lim_d  = 1'b1;
				cur_d  = cur_red_ua;
				volt_d = vreg_red_uv;
			end
			ACT_STOP: begin
				en_d = EN_OFF;
			end
			ACT_SHUTDOWN: begin
				shut_d = 1'b1;
			end
			default: ;
		endcase
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.simple || cmd.finish;
		end
	end

	logic [1:0]           kind_q, en_q;
	logic signed [TEMP_W-1:0] alow_q, ahigh_q;
	logic [3:0]           slot_q, act_q, hlth_q;
	logic                 lim_q, shut_q;
	logic [CUR_UA_W-1:0]  cur_q;
	logic [VREG_UV_W-1:0] volt_q;

	always_ff @(posedge clk) begin
		if (cmd.simple) begin
			kind_q  <= (opcode == OP_LOAD_WARM || opcode == OP_LOAD_COOL) ? KIND_LOAD
				: KIND_REJECT;
			alow_q  <= low_q;
			ahigh_q <= high_q;
			slot_q  <= '0;
			act_q   <= '0;
			hlth_q  <= '0;
			en_q    <= EN_NONE;
			lim_q   <= 1'b0;
			cur_q   <= '0;
			volt_q  <= '0;
			shut_q  <= 1'b0;
		end else if (cmd.finish) begin
			alow_q  <= rd.nlo;
			ahigh_q <= rd.nhi;
			if (op_q == OP_START) begin
				kind_q <= KIND_START;
				slot_q <= '0;
				act_q  <= '0;
				hlth_q <= '0;
				en_q   <= EN_NONE;
				lim_q  <= 1'b0;
				cur_q  <= '0;
				volt_q <= '0;
				shut_q <= 1'b0;
			end else begin
				kind_q <= KIND_EVENT;
				slot_q <= slot_wide[3:0];
				act_q  <= rd.action;
				hlth_q <= rd.health;
				en_q   <= en_d;
				lim_q  <= lim_d;
				cur_q  <= cur_d;
				volt_q <= volt_d;
				shut_q <= shut_d;
			end
		end
	end

	assign done             = done_q;
	assign result_kind      = kind_q;
	assign armed_low        = alow_q;
	assign armed_high       = ahigh_q;
	assign matched_slot     = slot_q;
	assign action_taken     = act_q;
	assign health_report    = hlth_q;
	assign enable_write     = en_q;
	assign limits_write     = lim_q;
	assign current_limit_ua = cur_q;
	assign voltage_limit_uv = volt_q;
	assign shutdown_notice  = shut_q;

	a_thr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(low_q) && $stable(high_q))
		else $error("armed thresholds moved outside a finishing beat");

	a_limits_enable: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && lim_q |-> en_q == EN_ON && kind_q == KIND_EVENT)
		else $error("limits posted without an enable on an event");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && kind_q == KIND_START |-> slot_q == '0 && en_q == EN_NONE && !shut_q)
		else $error("start result carries event fields");

	a_armed_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> alow_q == low_q && ahigh_q == high_q)
		else $error("reported armed pair differs from the armed registers");

endmodule

>>> rtl/core/battery_thermal_zone_stepper_unit.sv
`timescale 1ns / 1ps

// Battery thermal zone stepper. Items enter on start while busy is low; each
// item gives exactly one result, shown for one cycle with done high, and the
// receiver cannot stall it. Loads and rejected opcodes post their result the
// next cycle and leave busy low. A start reads warm slot 0 and keeps busy high
// while it does so. A warm or cool event walks its table downward from the last
// valid slot, one slot per clock through the table's registered read port, and
// busy stays high until a slot matches or slot 0 is reached. For a start or an
// event, done rises in the same cycle that busy falls. The config port is always
// ready; write it only while no item is in flight.
module battery_thermal_zone_stepper_unit
	import btz_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic [2:0]               opcode,
	input  logic [3:0]               entry_index,
	input  logic signed [TEMP_W-1:0] entry_threshold,
	input  logic signed [TEMP_W-1:0] entry_next_low,
	input  logic signed [TEMP_W-1:0] entry_next_high,
	input  logic [3:0]               entry_action,
	input  logic [3:0]               entry_health,
	output logic                     done,
	output logic [1:0]               result_kind,
	output logic signed [TEMP_W-1:0] armed_low,
	output logic signed [TEMP_W-1:0] armed_high,
	output logic [3:0]               matched_slot,
	output logic [3:0]               action_taken,
	output logic [3:0]               health_report,
	output logic [1:0]               enable_write,
	output logic                     limits_write,
	output logic [CUR_UA_W-1:0]      current_limit_ua,
	output logic [VREG_UV_W-1:0]     voltage_limit_uv,
	output logic                     shutdown_notice
);

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	btz_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	btz_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.entry_index      (entry_index),
		.entry_threshold  (entry_threshold),
		.entry_next_low   (entry_next_low),
		.entry_next_high  (entry_next_high),
		.entry_action     (entry_action),
		.entry_health     (entry_health),
		.done             (done),
		.result_kind      (result_kind),
		.armed_low        (armed_low),
		.armed_high       (armed_high),
		.matched_slot     (matched_slot),
		.action_taken     (action_taken),
		.health_report    (health_report),
		.enable_write     (enable_write),
		.limits_write     (limits_write),
		.current_limit_ua (current_limit_ua),
		.voltage_limit_uv (voltage_limit_uv),
		.shutdown_notice  (shutdown_notice)
	);

endmodule
